// ===== sv/sbmq_pkg.sv =====
// Shared constants and types for the shared-buffer multi-queue unit.
package sbmq_pkg;

    localparam int SLOTS_DEF  = 64;
    localparam int QUEUES_DEF = 4;

    localparam int QID_W  = 2;
    localparam int VAL_W  = 32;
    // s_tdata: queue_id then push_value, padded to whole bytes
    localparam int S_TDATA_W = ((QID_W + VAL_W + 7) / 8) * 8;
    localparam int M_TDATA_W = VAL_W;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    // controller -> datapath commands
    typedef struct packed {
        logic start;   // word accepted this cycle: issue reads, capture operands
        logic finish;  // FIN state: write back, load result register
    } t_cmd;

endpackage

// ===== sv/sbmq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module sbmq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/sbmq_ctrl.sv =====
// Handshake controller: two-state sequencer and output valid flag.
module sbmq_ctrl
    import sbmq_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_s_tvalid,
    output logic o_s_tready,
    output logic o_m_tvalid,
    input  logic i_m_tready,
    output t_cmd o_cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_FIN  = 1'b1;

    logic r_state, n_state;
    logic r_out_valid, n_out_valid;
    logic ready;

    // result register is free, or drains this same edge
    assign ready = (r_state == ST_IDLE) && (!r_out_valid || i_m_tready);

    always_comb begin
        o_cmd.start  = ready && i_s_tvalid;
        o_cmd.finish = (r_state == ST_FIN);
        n_state      = r_state;
        n_out_valid  = r_out_valid;
        if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            ST_IDLE: begin
                if (o_cmd.start) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                n_state     = ST_IDLE;
                n_out_valid = 1'b1;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_s_tready = ready;
    assign o_m_tvalid = r_out_valid;

endmodule

// ===== sv/sbmq_dp.sv =====
// Datapath: queue pointers, free list, fill count, slot stores, result register.
module sbmq_dp
    import sbmq_pkg::*;
#(
    parameter int SLOTS  = SLOTS_DEF,
    parameter int QUEUES = QUEUES_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_cmd                    i_cmd,
    input  logic                    i_op,
    input  logic [QID_W-1:0]        i_queue_id,
    input  logic signed [VAL_W-1:0] i_push_value,
    output logic                    o_ok,
    output logic signed [VAL_W-1:0] o_pop_value
);

    localparam int AW = $clog2(SLOTS);
    localparam int FW = $clog2(SLOTS + 1);
    // only queue numbers the 2-bit field can reach get storage
    localparam int QMAX = 1 << QID_W;
    localparam int QN   = (QUEUES < QMAX) ? QUEUES : QMAX;
    localparam int QW   = (QN > 1) ? $clog2(QN) : 1;
    localparam logic [QID_W:0] QLIM = (QID_W + 1)'(QN);
    localparam logic [FW-1:0]  SLOTS_F = FW'(SLOTS);

    // queue table
    logic [AW-1:0] r_head [QN];
    logic [AW-1:0] r_tail [QN];
    logic [QN-1:0] r_head_valid;
    // free list: linked free slots first, then untouched slots from r_fill up
    logic [AW-1:0] r_free_head;
    logic          r_free_valid;
    logic [FW-1:0] r_fill;

    // operands captured at accept
    logic                    r_op;
    logic [QID_W-1:0]        r_qid;
    logic signed [VAL_W-1:0] r_val;
    logic [AW-1:0]           r_hd, r_tl;
    logic                    r_hv;

    logic                    r_ok;
    logic signed [VAL_W-1:0] r_pop_value;

    logic [QW-1:0]  in_qi, qi;
    logic           in_range, push_ok, pop_ok, untouched;
    logic [AW-1:0]  rd_addr, link_waddr;
    logic [AW:0]    link_rdata, link_wdata;
    logic [VAL_W-1:0] data_rdata;
    logic           link_we, data_we;
    logic [FW-1:0]  idx_next;
    logic [AW-1:0]  n_free_head;
    logic           n_free_valid;

    assign in_qi = i_queue_id[QW-1:0];
    assign qi    = r_qid[QW-1:0];

    // push reads the free-head link, pop reads the head's link and data
    assign rd_addr = (i_op == OP_POP) ? r_head[in_qi] : r_free_head;

    assign in_range  = {1'b0, r_qid} < QLIM;
    assign push_ok   = in_range && (r_op == OP_PUSH) && r_free_valid;
    assign pop_ok    = in_range && (r_op == OP_POP) && r_hv;
    assign untouched = {{(FW-AW){1'b0}}, r_free_head} == r_fill;
    assign idx_next  = {{(FW-AW){1'b0}}, r_free_head} + FW'(1);

    always_comb begin
        if (untouched) begin
            n_free_head  = idx_next[AW-1:0];
            n_free_valid = idx_next < SLOTS_F;
        end else begin
            n_free_head  = link_rdata[AW-1:0];
            n_free_valid = link_rdata[AW];
        end
    end

    // push links the new slot after the tail; pop returns the head to the free list
    assign link_we    = i_cmd.finish && ((push_ok && r_hv) || pop_ok);
    assign link_waddr = (r_op == OP_PUSH) ? r_tl : r_hd;
    assign link_wdata = (r_op == OP_PUSH) ? {1'b1, r_free_head} : {r_free_valid, r_free_head};
    assign data_we    = i_cmd.finish && push_ok;

    sbmq_ram #(
        .WIDTH (AW + 1),
        .DEPTH (SLOTS)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (link_we),
        .i_waddr (link_waddr),
        .i_wdata (link_wdata),
        .i_raddr (rd_addr),
        .o_rdata (link_rdata)
    );

    sbmq_ram #(
        .WIDTH (VAL_W),
        .DEPTH (SLOTS)
    ) u_data_ram (
        .i_clk   (i_clk),
        .i_we    (data_we),
        .i_waddr (r_free_head),
        .i_wdata (r_val),
        .i_raddr (rd_addr),
        .o_rdata (data_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_op  <= i_op;
            r_qid <= i_queue_id;
            r_val <= i_push_value;
            r_hd  <= r_head[in_qi];
            r_tl  <= r_tail[in_qi];
            r_hv  <= r_head_valid[in_qi];
        end
        if (i_cmd.finish) begin
            r_ok        <= push_ok || pop_ok;
            r_pop_value <= pop_ok ? data_rdata : '0;
            if (push_ok) begin
                r_tail[qi] <= r_free_head;
                if (!r_hv) begin
                    r_head[qi] <= r_free_head;
                end
            end
            if (pop_ok) begin
                r_head[qi] <= link_rdata[AW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_valid <= '0;
            r_free_head  <= '0;
            r_free_valid <= 1'b1;
            r_fill       <= '0;
        end else if (i_cmd.finish) begin
            if (push_ok) begin
                r_head_valid[qi] <= 1'b1;
                r_free_head      <= n_free_head;
                r_free_valid     <= n_free_valid;
                if (untouched) begin
                    r_fill <= idx_next;
                end
            end
            if (pop_ok) begin
                // head == tail: this was the last entry
                r_head_valid[qi] <= (r_hd != r_tl);
                r_free_head      <= r_hd;
                r_free_valid     <= 1'b1;
            end
        end
    end

    assign o_ok        = r_ok;
    assign o_pop_value = r_pop_value;

endmodule

// ===== sv/shared_buffer_multi_queue_unit.sv =====
// Top level of the shared-buffer multi-queue unit: controller plus datapath.
// A result word is valid once the FIN state has loaded the result register. No new word is
//   taken while one is in flight, as the registered read of the slot link store at accept
//   precedes the pointer and link write-back in the next cycle, nor while a result waits.
// Reset: synchronous, active low; all queues empty, free list starts at slot 0.
//   No clearing pass: a fill count stands in for the initial free-list links.
module shared_buffer_multi_queue_unit
    import sbmq_pkg::*;
#(
    parameter int SLOTS  = SLOTS_DEF,   // slots in the shared store, 2..4096
    parameter int QUEUES = QUEUES_DEF   // queues, 1..64 (numbers above 3 unreachable)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // input words
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [S_TDATA_W-1:0] i_s_tdata,   // [1:0] queue_id, [33:2] push_value, rest 0
    input  logic                 i_s_tuser,   // [0] op: 0 push, 1 pop
    // result words
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [M_TDATA_W-1:0] o_m_tdata,   // [31:0] pop_value (0 unless a pop succeeded)
    output logic                 o_m_tuser    // [0] ok
);

    t_cmd cmd;
    logic signed [VAL_W-1:0] pop_value;

    sbmq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_cmd      (cmd)
    );

    sbmq_dp #(
        .SLOTS  (SLOTS),
        .QUEUES (QUEUES)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_op         (i_s_tuser),
        .i_queue_id   (i_s_tdata[QID_W-1:0]),
        .i_push_value (i_s_tdata[QID_W+VAL_W-1:QID_W]),
        .o_ok         (o_m_tuser),
        .o_pop_value  (pop_value)
    );

    assign o_m_tdata = pop_value;

endmodule
